/* rtl/abs_pkg.sv */
// Shared codes, widths and types of the buzzer pattern sequencer.
package abs_pkg;

  localparam int REG_W     = 16;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int WIDE_W    = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WARN_ON   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_OFF  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALRM_ON   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALRM_OFF  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_ON    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_GAP   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_PAUSE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_ON   = 4'd7;

  localparam logic [REG_W-1:0] RST_WARN_ON   = 16'd500;
  localparam logic [REG_W-1:0] RST_WARN_OFF  = 16'd500;
  localparam logic [REG_W-1:0] RST_ALRM_ON   = 16'd200;
  localparam logic [REG_W-1:0] RST_ALRM_OFF  = 16'd200;
  localparam logic [REG_W-1:0] RST_ERR_ON    = 16'd100;
  localparam logic [REG_W-1:0] RST_ERR_GAP   = 16'd100;
  localparam logic [REG_W-1:0] RST_ERR_PAUSE = 16'd1000;
  localparam logic [REG_W-1:0] RST_BEEP_ON   = 16'd100;

  // Operations
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Alarm types
  localparam logic [2:0] AT_NORMAL     = 3'd0;
  localparam logic [2:0] AT_INDICATION = 3'd1;
  localparam logic [2:0] AT_PREVENTIVE = 3'd2;
  localparam logic [2:0] AT_EMERGENCY  = 3'd3;
  localparam logic [2:0] AT_IND_PREV   = 3'd4;
  localparam logic [2:0] AT_IND_EMERG  = 3'd5;
  localparam logic [2:0] AT_ERROR      = 3'd6;
  localparam logic [2:0] AT_BEEP       = 3'd7;

  // Phase codes
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_STOP       = 4'd1;
  localparam logic [3:0] PH_WARN_START = 4'd2;
  localparam logic [3:0] PH_WARN_ON    = 4'd3;
  localparam logic [3:0] PH_WARN_OFF   = 4'd4;
  localparam logic [3:0] PH_ALRM_START = 4'd5;
  localparam logic [3:0] PH_ALRM_ON    = 4'd6;
  localparam logic [3:0] PH_ALRM_OFF   = 4'd7;
  localparam logic [3:0] PH_ERR_START  = 4'd8;
  localparam logic [3:0] PH_ERR_ON     = 4'd9;
  localparam logic [3:0] PH_ERR_GAP    = 4'd10;
  localparam logic [3:0] PH_ERR_ON2    = 4'd11;
  localparam logic [3:0] PH_ERR_PAUSE  = 4'd12;
  localparam logic [3:0] PH_BEEP_START = 4'd13;
  localparam logic [3:0] PH_BEEP_ON    = 4'd14;

  // Buzzer levels
  localparam logic [1:0] LVL_OFF  = 2'd0;
  localparam logic [1:0] LVL_LOW  = 2'd1;
  localparam logic [1:0] LVL_HIGH = 2'd2;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] dur_regs_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [3:0] saved_phase;
    logic [1:0] drive_level;
  } seq_state_t;

endpackage

/* rtl/abs_cfg_regs.sv */
// Duration register file of the buzzer pattern sequencer.
module abs_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [abs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abs_pkg::REG_W-1:0]   cfg_data,
  output abs_pkg::dur_regs_t          dur_regs
);
  import abs_pkg::*;

  dur_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_WARN_ON[2:0]]   <= RST_WARN_ON;
      regs_r[REG_WARN_OFF[2:0]]  <= RST_WARN_OFF;
      regs_r[REG_ALRM_ON[2:0]]   <= RST_ALRM_ON;
      regs_r[REG_ALRM_OFF[2:0]]  <= RST_ALRM_OFF;
      regs_r[REG_ERR_ON[2:0]]    <= RST_ERR_ON;
      regs_r[REG_ERR_GAP[2:0]]   <= RST_ERR_GAP;
      regs_r[REG_ERR_PAUSE[2:0]] <= RST_ERR_PAUSE;
      regs_r[REG_BEEP_ON[2:0]]   <= RST_BEEP_ON;
    end else if (cfg_we && !cfg_index[CFG_IDX_W-1]) begin
      // drop writes beyond the last register
      regs_r[cfg_index[CFG_IDX_W-2:0]] <= cfg_data;
    end
  end

  assign dur_regs = regs_r;

endmodule

/* rtl/abs_step.sv */
// Next-state logic of the pattern phase machine for one tick or request.
module abs_step #(
  parameter int TIMER_BITS = 16
) (
  input  logic                    op,
  input  logic [2:0]              alarm_type,
  input  abs_pkg::seq_state_t     cur,
  input  logic [TIMER_BITS-1:0]   timer,
  input  abs_pkg::dur_regs_t      dur_regs,
  output abs_pkg::seq_state_t     nxt,
  output logic [TIMER_BITS-1:0]   timer_nxt,
  output logic                    refresh
);
  import abs_pkg::*;

  logic [TIMER_BITS-1:0] dec;
  logic                  expired;
  logic                  load;
  logic [2:0]            load_idx;
  logic [WIDE_W-1:0]     load_wide;
  logic [TIMER_BITS-1:0] load_val;

  assign dec     = (timer == '0) ? '0 : timer - 1'b1;
  assign expired = (dec == '0);

  // saturate a duration to the timer range
  assign load_wide = {{(WIDE_W-REG_W){1'b0}}, dur_regs[load_idx]};
  assign load_val  = (|(load_wide >> TIMER_BITS)) ? '1 : load_wide[TIMER_BITS-1:0];

  always_comb begin
    nxt      = cur;
    refresh  = 1'b0;
    load     = 1'b0;
    load_idx = REG_WARN_ON[2:0];
    if (op == OP_REQUEST) begin
      nxt.saved_phase = cur.phase;
      case (alarm_type)
        AT_NORMAL, AT_INDICATION: nxt.phase = PH_STOP;
        AT_PREVENTIVE:            nxt.phase = PH_WARN_START;
        AT_EMERGENCY:             nxt.phase = PH_ALRM_START;
        AT_ERROR:                 nxt.phase = PH_ERR_START;
        AT_BEEP:                  nxt.phase = PH_BEEP_START;
        default:                  nxt.phase = cur.phase;
      endcase
    end else begin
      case (cur.phase)
        PH_WARN_START: begin
          load = 1'b1; load_idx = REG_WARN_ON[2:0];
          nxt.drive_level = LVL_LOW; nxt.phase = PH_WARN_ON;
        end
        PH_WARN_ON: if (expired) begin
          load = 1'b1; load_idx = REG_WARN_OFF[2:0]; refresh = 1'b1;
          nxt.drive_level = LVL_OFF; nxt.phase = PH_WARN_OFF;
        end
        PH_WARN_OFF: if (expired) begin
          load = 1'b1; load_idx = REG_WARN_ON[2:0];
          nxt.drive_level = LVL_LOW; nxt.phase = PH_WARN_ON;
        end
        PH_ALRM_START: begin
          load = 1'b1; load_idx = REG_ALRM_ON[2:0];
          nxt.drive_level = LVL_HIGH; nxt.phase = PH_ALRM_ON;
        end
        PH_ALRM_ON: if (expired) begin
          load = 1'b1; load_idx = REG_ALRM_OFF[2:0]; refresh = 1'b1;
          nxt.drive_level = LVL_OFF; nxt.phase = PH_ALRM_OFF;
        end
        PH_ALRM_OFF: if (expired) begin
          load = 1'b1; load_idx = REG_ALRM_ON[2:0];
          nxt.drive_level = LVL_HIGH; nxt.phase = PH_ALRM_ON;
        end
        PH_ERR_START: begin
          load = 1'b1; load_idx = REG_ERR_ON[2:0];
          nxt.drive_level = LVL_HIGH; nxt.phase = PH_ERR_ON;
        end
        PH_ERR_ON: if (expired) begin
          load = 1'b1; load_idx = REG_ERR_GAP[2:0]; refresh = 1'b1;
          nxt.drive_level = LVL_OFF; nxt.phase = PH_ERR_GAP;
        end
        PH_ERR_GAP: if (expired) begin
          load = 1'b1; load_idx = REG_ERR_ON[2:0];
          nxt.drive_level = LVL_HIGH; nxt.phase = PH_ERR_ON2;
        end
        PH_ERR_ON2: if (expired) begin
          load = 1'b1; load_idx = REG_ERR_PAUSE[2:0]; refresh = 1'b1;
          nxt.drive_level = LVL_OFF; nxt.phase = PH_ERR_PAUSE;
        end
        PH_ERR_PAUSE: if (expired) begin
          load = 1'b1; load_idx = REG_ERR_ON[2:0];
          nxt.drive_level = LVL_HIGH; nxt.phase = PH_ERR_ON;
        end
        PH_BEEP_START: begin
          load = 1'b1; load_idx = REG_BEEP_ON[2:0];
          nxt.drive_level = LVL_HIGH; nxt.phase = PH_BEEP_ON;
        end
        PH_BEEP_ON: if (expired) begin
          refresh = 1'b1;
          nxt.drive_level = LVL_OFF; nxt.phase = cur.saved_phase;
        end
        PH_STOP: begin
          refresh = 1'b1;
          nxt.drive_level = LVL_OFF; nxt.phase = PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  // requests leave the timer alone; ticks decrement and may reload
  assign timer_nxt = (op == OP_REQUEST) ? timer : (load ? load_val : dec);

endmodule

/* rtl/alarm_buzzer_pattern_sequencer.sv */
// Top level of the buzzer alarm pattern sequencer.
// Each input transfer is a tick (operation 0) or an alarm-type request
// (operation 1) and yields exactly one result transfer: the buzzer level, a
// refresh strobe raised when that item turned the buzzer off, and the phase
// code now in force. The block takes one item per clock while the output is
// not stalled. The input register holds the item; the phase machine and timer
// then update and load the output register, which holds the result while
// out_stall is high. The phase/timer state loop commits once per item. in_stall
// rises only when the input register is full and the output register is full
// and stalled. Duration registers are to be written by the user through the
// cfg port only while no item is in flight; the block does not enforce this.
// Indexes 8 and up are dropped. The timer is TIMER_BITS wide; durations beyond
// its range load as its maximum.
module alarm_buzzer_pattern_sequencer #(
  parameter int TIMER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [2:0]                     in_alarm_type,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_buzzer_drive,
  output logic                           out_refresh_pulse,
  output logic [3:0]                     out_pattern_state,
  // configuration
  input  logic                           cfg_we,
  input  logic [abs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abs_pkg::REG_W-1:0]      cfg_data
);
  import abs_pkg::*;

  dur_regs_t             dur_regs;

  // input register
  logic                  in_valid_r;
  logic                  in_op_r;
  logic [2:0]            in_type_r;

  // sequencer state
  seq_state_t            state_r;
  seq_state_t            state_nxt;
  logic [TIMER_BITS-1:0] timer_r;
  logic [TIMER_BITS-1:0] timer_nxt;
  logic                  refresh_nxt;

  // output register
  logic                  out_valid_r;
  logic [1:0]            drive_r;
  logic                  refresh_r;
  logic [3:0]            pstate_r;

  logic                  out_free;
  logic                  step_go;
  logic                  in_take;

  abs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .dur_regs (dur_regs)
  );

  abs_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .op        (in_op_r),
    .alarm_type(in_type_r),
    .cur       (state_r),
    .timer     (timer_r),
    .dur_regs  (dur_regs),
    .nxt       (state_nxt),
    .timer_nxt (timer_nxt),
    .refresh   (refresh_nxt)
  );

  // advance the output register when it is empty or being taken
  assign out_free = !out_valid_r || !out_stall;
  assign step_go  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r   <= in_operation;
      in_type_r <= in_alarm_type;
    end
  end

  // commit the phase machine once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_STOP;
      state_r.saved_phase <= PH_STOP;
      state_r.drive_level <= LVL_OFF;
      timer_r             <= '0;
    end else if (step_go) begin
      state_r <= state_nxt;
      timer_r <= timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_go;
    end
  end

  // hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (step_go) begin
      drive_r   <= state_nxt.drive_level;
      refresh_r <= refresh_nxt;
      pstate_r  <= state_nxt.phase;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_buzzer_drive  = drive_r;
  assign out_refresh_pulse = refresh_r;
  assign out_pattern_state = pstate_r;

endmodule

/* rtl/abs_checker.sv */
// Port-level checks of the buzzer pattern sequencer and their binding.
module abs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_buzzer_drive,
  input logic       out_refresh_pulse,
  input logic [3:0] out_pattern_state
);
  import abs_pkg::*;

  // a refresh strobe always comes with a silent buzzer
  a_refresh_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_refresh_pulse |-> out_buzzer_drive == LVL_OFF)
    else $error("refresh without buzzer off");

  // idle phase never keeps a tone on
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pattern_state == PH_IDLE |-> out_buzzer_drive == LVL_OFF)
    else $error("tone on in idle phase");

  // after reset no result is pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_buzzer_drive)
      && $stable(out_refresh_pulse) && $stable(out_pattern_state))
    else $error("stalled result changed");

  // input is only held off behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind alarm_buzzer_pattern_sequencer abs_checker u_abs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_buzzer_drive (out_buzzer_drive),
  .out_refresh_pulse(out_refresh_pulse),
  .out_pattern_state(out_pattern_state)
);
